// ----- rtl/ssrc_pkg.sv -----
// shared constants and types of the shadow stack return checker
package ssrc_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int ADDR_W      = 64;
  localparam int COUNT_W     = 64;
  localparam int STATUS_W    = 3;

  localparam logic ACT_CALL   = 1'b0;
  localparam logic ACT_RETURN = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_PUSHED   = 3'd0,
    ST_MATCHED  = 3'd1,
    ST_UNDER    = 3'd2,
    ST_MISMATCH = 3'd3,
    ST_OVER     = 3'd4,
    ST_HALTED   = 3'd5
  } status_t;

  typedef struct packed {
    logic              push;
    logic              pop;
    logic [ADDR_W-1:0] data;
  } stack_cmd_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic [ADDR_W-1:0]  top;
  } stack_stat_t;

endpackage

// ----- rtl/ssrc_if.sv -----
// valid/ready channel interfaces for the input and result beats

interface ssrc_in_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [ssrc_pkg::ADDR_W-1:0]  address;

  modport source (output valid, output action, output address, input ready);
  modport sink   (input valid, input action, input address, output ready);
endinterface

interface ssrc_out_if;
  logic                          valid;
  logic                          ready;
  logic [ssrc_pkg::STATUS_W-1:0] status;
  logic [ssrc_pkg::ADDR_W-1:0]   expected_target;
  logic [ssrc_pkg::COUNT_W-1:0]  call_count;

  modport source (output valid, output status, output expected_target, output call_count,
                  input ready);
  modport sink   (input valid, input status, input expected_target, input call_count,
                  output ready);
endinterface

// ----- rtl/ssrc_stack.sv -----
// shadow stack storage: entry memory, registered top of stack and depth counter
module ssrc_stack (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ssrc_pkg::stack_cmd_t   cmd,
  output ssrc_pkg::stack_stat_t  stat
);

  logic [ssrc_pkg::ADDR_W-1:0]  mem [ssrc_pkg::STACK_DEPTH];
  logic [ssrc_pkg::ADDR_W-1:0]  top_r;
  logic [ssrc_pkg::DEPTH_W-1:0] depth_r;
  logic [ssrc_pkg::DEPTH_W-1:0] depth_nxt;
  logic [ssrc_pkg::DEPTH_W-1:0] below;
  logic [ssrc_pkg::IDX_W-1:0]   wr_idx;
  logic [ssrc_pkg::IDX_W-1:0]   rd_idx;

  // entry under the top becomes the new top on a pop
  assign below  = depth_r - ssrc_pkg::DEPTH_W'(2);
  assign wr_idx = depth_r[ssrc_pkg::IDX_W-1:0];
  assign rd_idx = below[ssrc_pkg::IDX_W-1:0];

  always_comb begin
    depth_nxt = depth_r;
    if (cmd.push) begin
      depth_nxt = depth_r + ssrc_pkg::DEPTH_W'(1);
    end else if (cmd.pop) begin
      depth_nxt = depth_r - ssrc_pkg::DEPTH_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else begin
      depth_r <= depth_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_idx] <= cmd.data;
      top_r       <= cmd.data;
    end else if (cmd.pop) begin
      top_r <= mem[rd_idx];
    end
  end

  assign stat.depth = depth_r;
  assign stat.top   = top_r;

endmodule

// ----- rtl/shadow_stack_return_checker.sv -----
// shadow call stack return checker top level
//
// in_if carries one beat per call or return: action (0 call, 1 return) and
// address (return address for a call, actual target for a return).
// out_if returns exactly one beat per input beat, in order: status,
// expected_target (address popped by a return, else zero) and call_count.
// Each beat is registered on entry and checked against the registered top
// of stack while it sits in the input register; its result then goes to
// the result register, which holds while out_if.ready is low.
// One beat is taken per cycle sustained with out_if.ready high; the stack
// memory has one write port for pushes and one read port that refills the
// top register on pops, so calls and returns may alternate freely.
// After an underflow, mismatch or overflow the block is halted and answers
// halted for every later beat.
// rst_n (synchronous, active low) empties the stack, clears the call count
// and the halt, and drops any beat in flight; no clearing pass is needed.
// When the receiver holds out_if.ready low the result register holds and
// the input register takes one more beat if empty before in_if.ready drops.
module shadow_stack_return_checker (
  input  logic              clk,
  input  logic              rst_n,
  ssrc_in_if.sink           in_if,
  ssrc_out_if.source        out_if
);

  logic                           s1_valid_r;
  logic                           s1_action_r;
  logic [ssrc_pkg::ADDR_W-1:0]    s1_addr_r;
  logic                           adv;
  logic                           fire;

  logic                           halted_r;
  logic                           halted_nxt;
  logic [ssrc_pkg::COUNT_W-1:0]   calls_r;
  logic [ssrc_pkg::COUNT_W-1:0]   calls_nxt;

  logic                           out_valid_r;
  ssrc_pkg::status_t              status_r;
  ssrc_pkg::status_t              status_nxt;
  logic [ssrc_pkg::ADDR_W-1:0]    expected_r;
  logic [ssrc_pkg::ADDR_W-1:0]    expected_nxt;
  logic [ssrc_pkg::COUNT_W-1:0]   count_r;

  ssrc_pkg::stack_cmd_t           cmd;
  ssrc_pkg::stack_stat_t          stat;

  assign adv         = !out_valid_r || out_if.ready;
  assign fire        = s1_valid_r && adv;
  assign in_if.ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      s1_action_r <= in_if.action;
      s1_addr_r   <= in_if.address;
    end
  end

  ssrc_stack u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .stat  (stat)
  );

  always_comb begin
    cmd.push     = 1'b0;
    cmd.pop      = 1'b0;
    cmd.data     = s1_addr_r;
    halted_nxt   = halted_r;
    calls_nxt    = calls_r;
    status_nxt   = ssrc_pkg::ST_HALTED;
    expected_nxt = '0;
    priority if (halted_r) begin
      status_nxt = ssrc_pkg::ST_HALTED;
    end else if (s1_action_r == ssrc_pkg::ACT_CALL) begin
      calls_nxt = calls_r + ssrc_pkg::COUNT_W'(1);
      if (stat.depth >= ssrc_pkg::DEPTH_W'(ssrc_pkg::STACK_DEPTH)) begin
        status_nxt = ssrc_pkg::ST_OVER;
        halted_nxt = 1'b1;
      end else begin
        cmd.push   = fire;
        status_nxt = ssrc_pkg::ST_PUSHED;
      end
    end else begin
      if (stat.depth == '0) begin
        status_nxt = ssrc_pkg::ST_UNDER;
        halted_nxt = 1'b1;
      end else begin
        cmd.pop      = fire;
        expected_nxt = stat.top;
        if (stat.top == s1_addr_r) begin
          status_nxt = ssrc_pkg::ST_MATCHED;
        end else begin
          status_nxt = ssrc_pkg::ST_MISMATCH;
          halted_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      halted_r    <= 1'b0;
      calls_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        halted_r <= halted_nxt;
        calls_r  <= calls_nxt;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status_r   <= status_nxt;
      expected_r <= expected_nxt;
      count_r    <= calls_nxt;
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.status          = status_r;
  assign out_if.expected_target = expected_r;
  assign out_if.call_count      = count_r;

endmodule
